@@ rtl/core/sblc_pkg.sv @@
// Shared widths, result codes and controller/datapath signal groups for the sector buffer.
`default_nettype none

package sblc_pkg;

  // Field widths.
  localparam int unsigned SECTOR_W = 16;
  localparam int unsigned NOW_W    = 32;
  localparam int unsigned DISK_W   = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 3;

  // Configuration and sizing defaults.
  localparam logic [DISK_W-1:0] DISK_SECTORS_RST = 16'd2880;
  localparam int unsigned       SLOTS_DEF        = 8;

  // Result codes carried in the status field.
  typedef enum logic [STATUS_W-1:0] {
    RES_HIT    = 2'd0,
    RES_FILLED = 2'd1,
    RES_FAILED = 2'd2,
    RES_OOB    = 2'd3
  } res_status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;  // capture an accepted request
    logic lookup;    // range check and tag compare, refresh on a hit
    logic scan;      // one step of the least-recently-used search
    logic commit;    // retag the victim
    logic out_load;  // move the finished result into the output register
  } sblc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic oob;        // sector lies beyond the disk
    logic hit;        // a valid slot holds the sector
    logic scan_last;  // the search is on its final slot
  } sblc_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/sblc_req_if.sv @@
// Request channel interface: sector number, timestamp and fill outcome.
`default_nettype none

interface sblc_req_if;
  logic                          valid;
  logic                          ready;
  logic [sblc_pkg::SECTOR_W-1:0] sector;
  logic [sblc_pkg::NOW_W-1:0]    now;
  logic                          fill_ok;

  modport source (output valid, output sector, output now, output fill_ok, input ready);
  modport sink   (input valid, input sector, input now, input fill_ok, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sblc_rsp_if.sv @@
// Response channel interface: result code and buffer slot.
`default_nettype none

interface sblc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sblc_pkg::STATUS_W-1:0] status;
  logic [sblc_pkg::SLOT_W-1:0]   slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sblc_ctrl.sv @@
// Controller state machine sequencing lookup, victim search, retag and result hand-off.
`default_nettype none

module sblc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire sblc_pkg::sblc_sts_t sts_i,
  output sblc_pkg::sblc_cmd_t      cmd_o
);
  import sblc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_COMMIT,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.load_req = accept;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = (sts_i.oob || sts_i.hit) ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  a_accept_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_LOOKUP)
    else $error("accepted request did not enter lookup");

  a_scan_end_commits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && sts_i.scan_last) |=> state_q == ST_COMMIT)
    else $error("victim search end did not lead to retag");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.out_load)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ rtl/core/sblc_dp.sv @@
// Datapath: tag store, valid bits, last-use memory, victim search and result registers.
`default_nettype none

module sblc_dp #(
  parameter int unsigned SLOTS = sblc_pkg::SLOTS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sblc_pkg::DISK_W-1:0]   cfg_wdata_i,
  input  wire logic [sblc_pkg::SECTOR_W-1:0] sector_i,
  input  wire logic [sblc_pkg::NOW_W-1:0]    now_i,
  input  wire logic                          fill_ok_i,
  input  wire sblc_pkg::sblc_cmd_t           cmd_i,
  output sblc_pkg::sblc_sts_t                sts_o,
  output logic [sblc_pkg::STATUS_W-1:0]      status_o,
  output logic [sblc_pkg::SLOT_W-1:0]        slot_o
);
  import sblc_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);

  logic [DISK_W-1:0]   disk_sectors_q;
  logic [SECTOR_W-1:0] sec_q;
  logic [NOW_W-1:0]    now_q;
  logic                ok_q;

  logic [SECTOR_W-1:0] tag_q [SLOTS];
  logic [SLOTS-1:0]    valid_q;
  logic [SLOTS-1:0]    lu_set_q;
  logic [NOW_W-1:0]    lu_mem [SLOTS];

  logic [SLOTS-1:0]    match;
  logic [IDX_W-1:0]    hit_idx;
  logic                oob;

  logic [IDX_W-1:0]    idx_q;
  logic [IDX_W-1:0]    rd_addr;
  logic [NOW_W-1:0]    rd_data_q;
  logic                rd_set_q;
  logic [NOW_W-1:0]    rd_eff;
  logic [NOW_W-1:0]    best_q;
  logic [IDX_W-1:0]    pick_q;

  logic                lu_we;
  logic [IDX_W-1:0]    lu_wa;
  logic                hit_write;

  res_status_e         res_status_q;
  logic [SLOT_W-1:0]   res_slot_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SLOT_W-1:0]   out_slot_q;

  // Sector zero is always inside the disk.
  assign oob = (sec_q != '0) && (sec_q >= disk_sectors_q);

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      match[k] = valid_q[k] && (tag_q[k] == sec_q);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (match[k]) hit_idx = IDX_W'(k);
    end
  end

  assign sts_o.oob       = oob;
  assign sts_o.hit       = |match;
  assign sts_o.scan_last = (idx_q == IDX_W'(SLOTS - 1));

  assign hit_write = cmd_i.lookup && !oob && (|match);
  assign lu_we     = hit_write || (cmd_i.commit && ok_q);
  assign lu_wa     = cmd_i.commit ? pick_q : hit_idx;
  assign rd_addr   = cmd_i.lookup ? '0 : idx_q + IDX_W'(1);
  assign rd_eff    = rd_set_q ? rd_data_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_sectors_q <= DISK_SECTORS_RST;
      valid_q        <= '0;
      lu_set_q       <= '0;
    end else begin
      if (cfg_we_i) disk_sectors_q <= cfg_wdata_i;
      if (lu_we) lu_set_q[lu_wa] <= 1'b1;
      if (cmd_i.commit) valid_q[pick_q] <= ok_q;
    end
  end

  // Last-use memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (lu_we) lu_mem[lu_wa] <= now_q;
    rd_data_q <= lu_mem[rd_addr];
    rd_set_q  <= lu_set_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      sec_q <= sector_i;
      now_q <= now_i;
      ok_q  <= fill_ok_i;
    end
    if (cmd_i.commit) tag_q[pick_q] <= sec_q;
  end

  // Victim search: strict less-than keeps the lowest index on a tie.
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      idx_q <= '0;
    end else if (cmd_i.scan) begin
      idx_q <= idx_q + IDX_W'(1);
      if (idx_q == '0 || rd_eff < best_q) begin
        best_q <= rd_eff;
        pick_q <= idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      if (oob) begin
        res_status_q <= RES_OOB;
        res_slot_q   <= '0;
      end else begin
        res_status_q <= RES_HIT;
        res_slot_q   <= SLOT_W'(hit_idx);
      end
    end else if (cmd_i.commit) begin
      res_status_q <= ok_q ? RES_FILLED : RES_FAILED;
      res_slot_q   <= SLOT_W'(pick_q);
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
    end
  end

  assign status_o = out_status_q;
  assign slot_o   = out_slot_q;

  a_unique_tags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match))
    else $error("sector held by more than one valid slot");

  a_fill_validates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && ok_q) |=> valid_q[$past(pick_q)])
    else $error("successful fill left victim invalid");

  a_oob_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.lookup && oob) |=> (res_status_q == RES_OOB && res_slot_q == '0))
    else $error("out-of-disk request gave wrong result");

endmodule

`default_nettype wire

@@ rtl/core/sector_buffer_lru_cache_core.sv @@
// Top level of the sector buffer tag and replacement controller.
`default_nettype none

// A small fully associative sector buffer of SLOTS entries. Each request
// carries a sector number, a timestamp and the outcome of the device fill;
// each produces exactly one response with a result code and a slot. A
// nonzero sector at or beyond disk_sectors is rejected without touching any
// state. A hit refreshes the slot's last-use time. On a miss the slot with
// the oldest last-use time is chosen (lowest index on a tie), retagged, and
// becomes valid with a fresh time only if the fill succeeds; otherwise it is
// left invalid with its old time. The victim search reads one last-use entry
// per cycle through the single read port of the last-use memory. A finished
// response waits in an output register, so the next request is accepted
// while it is still pending. A finished result that finds the previous
// response still untaken waits until that response is taken. The
// disk_sectors register may only be written while no request is in flight.
module sector_buffer_lru_cache_core #(
  parameter int unsigned SLOTS = sblc_pkg::SLOTS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [sblc_pkg::DISK_W-1:0] cfg_wdata_i,
  sblc_req_if.sink                         req_i,
  sblc_rsp_if.source                       rsp_o
);
  import sblc_pkg::*;

  sblc_cmd_t cmd;
  sblc_sts_t sts;

  // The controller owns the handshakes and the sequencing; it sees only the
  // three status flags from the datapath.
  sblc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the configuration register, the tag and valid
  // stores, the last-use memory and the response register.
  sblc_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sector_i    (req_i.sector),
    .now_i       (req_i.now),
    .fill_ok_i   (req_i.fill_ok),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .status_o    (rsp_o.status),
    .slot_o      (rsp_o.slot)
  );

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the sector buffer tag and replacement controller.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sblc_pkg::*;

  localparam int unsigned SLOTS       = SLOTS_DEF;
  // A miss is the slowest request: its victim search steps through every slot.
  localparam int unsigned MISS_CYCLES = SLOTS + 4;
  localparam int unsigned SETTLE      = 2 * MISS_CYCLES;
  localparam int unsigned WORK_SET    = 12;
  // About 1750 requests are sent in all, each with its busy time, request gap and response stall;
  // the limit leaves ample room above their sum.
  localparam int unsigned CYCLE_LIMIT = 800000;

  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [NOW_W-1:0]    now;
    logic                fill_ok;
  } sector_req_t;

  typedef struct packed {
    res_status_e         status;
    logic [SLOT_W-1:0]   slot;
  } sector_rsp_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [DISK_W-1:0]   cfg_wdata_i;

  sblc_req_if req_if ();
  sblc_rsp_if rsp_if ();

  sector_buffer_lru_cache_core #(
    .SLOTS (SLOTS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the buffer's tag store and the disk size register.
  logic [DISK_W-1:0]   disk_size;
  logic [SECTOR_W-1:0] buf_tag   [SLOTS];
  logic                buf_valid [SLOTS];
  logic [NOW_W-1:0]    buf_stamp [SLOTS];

  sector_req_t         request_q [$];
  sector_rsp_t         outcome_q [$];
  sector_req_t         req_held;
  logic [SECTOR_W-1:0] work_set [WORK_SET];
  logic [NOW_W-1:0]    now_stamp;

  bit                  calm;
  int unsigned         req_gap;
  int unsigned         rsp_hold;
  int unsigned         sent_cnt;
  int unsigned         fail_cnt;
  int unsigned         cycle_cnt;
  int unsigned         n_hit, n_fill, n_fail, n_oob;

  // Works out the response to one request and updates the shadow buffer, exactly as the
  // controller should: range check first, then tag match, then least-recently-used refill.
  function automatic sector_rsp_t cache_lookup(sector_req_t rq);
    sector_rsp_t       rs;
    int unsigned       victim;
    logic [NOW_W-1:0]  oldest;
    rs.slot = '0;
    if (rq.sector != '0 && rq.sector >= disk_size) begin
      rs.status = RES_OOB;
      return rs;
    end
    for (int k = 0; k < SLOTS; k++) begin
      if (buf_valid[k] && buf_tag[k] == rq.sector) begin
        buf_stamp[k] = rq.now;
        rs.status    = RES_HIT;
        rs.slot      = SLOT_W'(k);
        return rs;
      end
    end
    // Strict less-than keeps the lowest index on a tie.
    victim = 0;
    oldest = buf_stamp[0];
    for (int k = 1; k < SLOTS; k++) begin
      if (buf_stamp[k] < oldest) begin
        oldest = buf_stamp[k];
        victim = k;
      end
    end
    buf_tag[victim]   = rq.sector;
    buf_valid[victim] = rq.fill_ok;
    if (rq.fill_ok) begin
      buf_stamp[victim] = rq.now;
      rs.status         = RES_FILLED;
    end else begin
      rs.status = RES_FAILED;
    end
    rs.slot = SLOT_W'(victim);
    return rs;
  endfunction

  // Idle length for either side: mostly none, sometimes short, rarely a long pause.
  // During calm stretches neither side idles at all.
  function automatic int unsigned draw_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // A fresh working set of in-range sectors; twelve of them for eight slots forces evictions.
  function automatic void pick_work_set();
    for (int k = 0; k < WORK_SET; k++) begin
      work_set[k] = (disk_size <= 1) ? '0 : SECTOR_W'($urandom_range(0, disk_size - 1));
    end
    work_set[0] = '0;
    if (disk_size > 1) work_set[1] = disk_size - DISK_W'(1);
  endfunction

  function automatic sector_req_t random_request();
    sector_req_t rq;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      rq.sector = work_set[$urandom_range(0, WORK_SET - 1)];
    end else if (roll < 82) begin
      // Beyond the disk; when the disk spans every sector only the top one is rejected.
      if (disk_size == '1) rq.sector = '1;
      else rq.sector = SECTOR_W'($urandom_range((disk_size == '0) ? 1 : disk_size, 16'hFFFF));
    end else begin
      rq.sector = SECTOR_W'($urandom());
    end
    roll = $urandom_range(0, 99);
    if (roll < 88) begin
      now_stamp = now_stamp + $urandom_range(0, 3);
      rq.now    = now_stamp;
    end else if (roll < 94) begin
      rq.now = $urandom();
    end else if (roll < 97) begin
      rq.now = '0;
    end else begin
      rq.now = '1;
    end
    rq.fill_ok = ($urandom_range(0, 99) < 85);
    return rq;
  endfunction

  function automatic void queue_request(logic [SECTOR_W-1:0] sector, logic [NOW_W-1:0] now,
                                        logic fill_ok);
    sector_req_t rq;
    rq.sector  = sector;
    rq.now     = now;
    rq.fill_ok = fill_ok;
    request_q.push_back(rq);
  endfunction

  // Polled on the falling edge so that queue sizes and valid have settled for the cycle.
  task automatic wait_drained();
    while (request_q.size() != 0 || req_if.valid || outcome_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic set_disk(logic [DISK_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    disk_size    = value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_random(int unsigned count);
    pick_work_set();
    repeat (count) request_q.push_back(random_request());
    wait_drained();
  endtask

  // Request driver. A request stays on the channel until it is taken; the response it
  // should produce is worked out at the very edge where it is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        outcome_q.push_back(cache_lookup(req_held));
        sent_cnt++;
        // Now and then switch into or out of a stretch with no idling on either side.
        if (sent_cnt % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_gap != 0) begin
          req_gap--;
          req_if.valid <= 1'b0;
        end else if (request_q.size() != 0) begin
          req_held        = request_q.pop_front();
          req_if.valid   <= 1'b1;
          req_if.sector  <= req_held.sector;
          req_if.now     <= req_held.now;
          req_if.fill_ok <= req_held.fill_ok;
          req_gap         = draw_gap();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: every response taken is checked against the oldest outstanding one.
  always @(posedge clk_i) begin : rsp_monitor
    sector_rsp_t want;
    logic        taken;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      taken = rsp_if.valid && rsp_if.ready;
      if (taken) begin
        if (outcome_q.size() == 0) begin
          $error("response with none outstanding: status %0d, slot %0d",
                 rsp_if.status, rsp_if.slot);
          fail_cnt++;
        end else begin
          want = outcome_q.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, rsp_if.status);
            fail_cnt++;
          end
          if (rsp_if.slot !== want.slot) begin
            $error("slot mismatch: expected %0d, got %0d", want.slot, rsp_if.slot);
            fail_cnt++;
          end
          case (want.status)
            RES_HIT:    n_hit++;
            RES_FILLED: n_fill++;
            RES_FAILED: n_fail++;
            default:    n_oob++;
          endcase
        end
      end
      // Back-pressure: stalls begin after a response or at random while waiting for one.
      if (rsp_hold != 0) rsp_hold--;
      else if (taken || $urandom_range(0, 3) == 0) rsp_hold = draw_gap();
      rsp_if.ready <= (rsp_hold == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses outstanding",
               cycle_cnt, outcome_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    req_if.valid   = 1'b0;
    req_if.sector  = '0;
    req_if.now     = '0;
    req_if.fill_ok = 1'b0;
    rsp_if.ready   = 1'b0;
    disk_size      = DISK_SECTORS_RST;
    for (int k = 0; k < SLOTS; k++) begin
      buf_tag[k]   = '0;
      buf_valid[k] = 1'b0;
      buf_stamp[k] = '0;
    end
    now_stamp = 32'd200;
    calm      = 1'b0;
    req_gap   = 0;
    rsp_hold  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed requests on the reset disk size. All last-use times start at zero, so the
    // first misses land on the lowest free index.
    queue_request(16'd0,    32'd0,          1'b1);  // sector zero, first miss
    queue_request(16'd0,    32'd100,        1'b1);  // hit refreshes slot 0
    queue_request(16'd2879, 32'd101,        1'b1);  // last sector on the disk
    queue_request(16'd2880, 32'd102,        1'b1);  // first sector past the end
    queue_request(16'hFFFF, 32'd103,        1'b1);  // top sector, out of disk
    queue_request(16'd7,    32'd104,        1'b0);  // fill fails, slot left invalid
    queue_request(16'd7,    32'd105,        1'b1);  // so the same sector misses again
    queue_request(16'd300,  32'hFFFF_FFFF,  1'b1);  // newest possible timestamp
    queue_request(16'd300,  32'hFFFF_FFFF,  1'b0);  // hit ignores the fill outcome
    queue_request(16'd2879, 32'd0,          1'b1);  // hit pulls a slot back to time zero
    queue_request(16'd55,   32'd106,        1'b1);  // tie at zero, lowest index evicted
    queue_request(16'd2879, 32'd107,        1'b1);  // the evicted sector now misses
    run_random(380);

    // Disk size zero: only sector zero gets through.
    set_disk(16'd0);
    queue_request(16'd0,    32'd110,        1'b1);
    queue_request(16'd1,    32'd111,        1'b1);
    queue_request(16'hFFFF, 32'd112,        1'b1);
    run_random(50);

    // Largest disk: every sector but the top one is in range.
    set_disk(16'hFFFF);
    queue_request(16'hFFFE, 32'd120,        1'b1);
    queue_request(16'hFFFF, 32'd121,        1'b1);
    queue_request(16'd0,    32'd122,        1'b0);
    run_random(420);

    // Disk size one: sector zero alone.
    set_disk(16'd1);
    queue_request(16'd0,    32'd130,        1'b1);
    queue_request(16'd1,    32'd131,        1'b1);
    run_random(50);

    // Sixteen sectors for eight slots keeps the replacement logic busy.
    set_disk(16'd16);
    run_random(420);

    set_disk(DISK_W'($urandom_range(17, 16'hFFFE)));
    run_random(400);

    repeat (SETTLE) @(posedge clk_i);
    $display("Checked %0d responses across six disk sizes: %0d hits, %0d fills,", 
             n_hit + n_fill + n_fail + n_oob, n_hit, n_fill);
    $display("%0d failed fills and %0d out-of-disk rejections.", n_fail, n_oob);
    if (fail_cnt == 0 && outcome_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/sblc_pkg.sv
rtl/core/sblc_req_if.sv
rtl/core/sblc_rsp_if.sv
rtl/core/sblc_ctrl.sv
rtl/core/sblc_dp.sv
rtl/core/sector_buffer_lru_cache_core.sv
verif/testbench.sv
